>>> rtl/core/ipd_pkg.sv
// Package for the infrared pulse-distance decoder: codes, constants and the
// item types passed between the front end, the queues and the decoder core.
// No dependencies.
`default_nettype none

package ipd_pkg;

  localparam int unsigned THRESH_W    = 13;
  localparam int unsigned COUNT_W     = 16;
  localparam int unsigned SCALE_SHIFT = 3;
  localparam int unsigned BYTE_W      = 8;
  localparam int unsigned INDEX_W     = 5;
  localparam int unsigned EDGE_W      = 8;

  localparam logic [THRESH_W-1:0] THRESHOLD_RESET = 13'd1000;

  localparam int unsigned CMD_DEPTH = 2;
  localparam int unsigned RES_DEPTH = 2;

  localparam logic OP_EDGE  = 1'b0;
  localparam logic OP_CLEAR = 1'b1;

  typedef struct packed {
    logic is_clear;
    logic one_bit;
  } cmd_t;

  typedef struct packed {
    logic               byte_valid;
    logic [BYTE_W-1:0]  byte_value;
    logic [INDEX_W-1:0] byte_index;
    logic [EDGE_W-1:0]  edge_count;
  } result_t;

endpackage

`default_nettype wire

>>> rtl/core/ir_pulse_distance_decoder_top.sv
// Infrared pulse-distance decoder, top level. Depends on ipd_pkg, ipd_front,
// ipd_fifo and ipd_back.
// Throughput: one item per cycle, set by the decoder core step, while neither
// queue stalls. An accepted item is registered in the command queue, then its
// result in the result queue, and sits on the out_ ports; stalls add delay.
// Reset: synchronous, active low; threshold returns to 1000, decoder disarmed,
// counters and both queues emptied. No clearing pass.
`default_nettype none

module ir_pulse_distance_decoder_top #(
  parameter int unsigned CMD_DEPTH = ipd_pkg::CMD_DEPTH,
  parameter int unsigned RES_DEPTH = ipd_pkg::RES_DEPTH
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  // configuration
  input  wire logic                         cfg_wr_en,
  input  wire logic [ipd_pkg::THRESH_W-1:0] cfg_wr_data,
  // input channel
  input  wire logic                         in_push,
  output logic                              in_full,
  input  wire logic                         in_op,
  input  wire logic [ipd_pkg::COUNT_W-1:0]  in_capture_count,
  // result channel
  output logic                              out_empty,
  input  wire logic                         out_pop,
  output logic                              out_byte_valid,
  output logic [ipd_pkg::BYTE_W-1:0]        out_byte_value,
  output logic [ipd_pkg::INDEX_W-1:0]       out_byte_index,
  output logic [ipd_pkg::EDGE_W-1:0]        out_edge_count
);

  import ipd_pkg::*;

  localparam int unsigned CMD_W = $bits(cmd_t);
  localparam int unsigned RES_W = $bits(result_t);

  cmd_t             front_cmd;
  cmd_t             core_cmd;
  logic [CMD_W-1:0] core_cmd_bits;
  logic             cmd_empty;
  logic             core_take;
  result_t          core_res;
  logic             res_full;
  logic [RES_W-1:0] out_bits;
  result_t          out_res;

  // Classify the item and read the threshold in the same cycle it is accepted.
  ipd_front u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data),
    .in_op            (in_op),
    .in_capture_count (in_capture_count),
    .cmd              (front_cmd)
  );

  // Decouple the front end from the decoder core.
  ipd_fifo #(
    .WIDTH (CMD_W),
    .DEPTH (CMD_DEPTH)
  ) u_cmd_q (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_push),
    .push_data (front_cmd),
    .full      (in_full),
    .pop       (core_take),
    .pop_data  (core_cmd_bits),
    .empty     (cmd_empty)
  );

  assign core_cmd = cmd_t'(core_cmd_bits);

  // Advance decoder state only when the result queue has room.
  ipd_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (!cmd_empty),
    .cmd       (core_cmd),
    .res_ready (!res_full),
    .take      (core_take),
    .res       (core_res)
  );

  // Hold finished items until the consumer pops them.
  ipd_fifo #(
    .WIDTH (RES_W),
    .DEPTH (RES_DEPTH)
  ) u_res_q (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (core_take),
    .push_data (core_res),
    .full      (res_full),
    .pop       (out_pop),
    .pop_data  (out_bits),
    .empty     (out_empty)
  );

  assign out_res        = result_t'(out_bits);
  assign out_byte_valid = out_res.byte_valid;
  assign out_byte_value = out_res.byte_value;
  assign out_byte_index = out_res.byte_index;
  assign out_edge_count = out_res.edge_count;

endmodule

`default_nettype wire

>>> rtl/core/ipd_fifo.sv
// Small register queue with first-word-fall-through output.
// Generic; depends on nothing.
`default_nettype none

module ipd_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] push_data,
  output logic                  full,
  input  wire logic             pop,
  output logic [WIDTH-1:0]      pop_data,
  output logic                  empty
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push, do_pop;

  assign full     = (count_r == FULL_CNT);
  assign empty    = (count_r == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/ipd_front.sv
// Front end: holds the threshold register, scales each capture count and
// classifies the item into a decoder command. Depends on ipd_pkg.
`default_nettype none

module ipd_front (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           cfg_wr_en,
  input  wire logic [ipd_pkg::THRESH_W-1:0]   cfg_wr_data,
  input  wire logic                           in_op,
  input  wire logic [ipd_pkg::COUNT_W-1:0]    in_capture_count,
  output ipd_pkg::cmd_t                       cmd
);

  import ipd_pkg::*;

  logic [THRESH_W-1:0] threshold_r;
  logic [THRESH_W-1:0] scaled;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      threshold_r <= THRESHOLD_RESET;
    end else if (cfg_wr_en) begin
      threshold_r <= cfg_wr_data;
    end
  end

  // Divide by eight: drop the low bits.
  assign scaled = in_capture_count[COUNT_W-1:SCALE_SHIFT];

  assign cmd.is_clear = (in_op == OP_CLEAR);
  assign cmd.one_bit  = (scaled > threshold_r);

endmodule

`default_nettype wire

>>> rtl/core/ipd_back.sv
// Decoder core: edge counter, bit position and byte packing, one command per
// cycle while the result queue has room. Depends on ipd_pkg.
`default_nettype none

module ipd_back (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          cmd_valid,
  input  wire ipd_pkg::cmd_t cmd,
  input  wire logic          res_ready,
  output logic               take,
  output ipd_pkg::result_t   res
);

  import ipd_pkg::*;

  logic              armed_r, armed_nxt;
  logic [EDGE_W-1:0] edges_r, edges_nxt;
  logic [EDGE_W-1:0] bitpos_r, bitpos_nxt;
  logic [BYTE_W-1:0] pack_r, pack_nxt;
  logic [BYTE_W-1:0] merged;
  logic              data_edge;

  assign take      = cmd_valid && res_ready;
  // Odd edge from 3 upward carries a data bit.
  assign data_edge = edges_r[0] && (edges_r[EDGE_W-1:1] != '0);
  assign merged    = pack_r | (BYTE_W'(cmd.one_bit) << bitpos_r[2:0]);

  always_comb begin
    armed_nxt  = armed_r;
    edges_nxt  = edges_r;
    bitpos_nxt = bitpos_r;
    pack_nxt   = pack_r;
    res        = '0;
    if (cmd.is_clear) begin
      edges_nxt  = '0;
      bitpos_nxt = '0;
      pack_nxt   = '0;
    end else if (!armed_r) begin
      armed_nxt = 1'b1;
    end else begin
      if (data_edge) begin
        pack_nxt = merged;
        if (bitpos_r[2:0] == 3'd7) begin
          res.byte_valid = 1'b1;
          res.byte_value = merged;
          res.byte_index = bitpos_r[EDGE_W-1:3];
          pack_nxt       = '0;
        end
        bitpos_nxt = bitpos_r + EDGE_W'(1);
      end
      edges_nxt = edges_r + EDGE_W'(1);
    end
    res.edge_count = edges_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      armed_r  <= 1'b0;
      edges_r  <= '0;
      bitpos_r <= '0;
      pack_r   <= '0;
    end else if (take) begin
      armed_r  <= armed_nxt;
      edges_r  <= edges_nxt;
      bitpos_r <= bitpos_nxt;
      pack_r   <= pack_nxt;
    end
  end

endmodule

`default_nettype wire

>>> dv/testbench.sv
// Self-checking testbench for ir_pulse_distance_decoder_top: directed edges, then framed
// and noisy random traffic under several threshold settings, checked against a local
// decoder model. Depends on ipd_pkg and the RTL of the decoder top level.
`default_nettype none

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import ipd_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 300000;
  localparam int unsigned LONG_STALL  = 250;

  // One input item as the sender offers it.
  typedef struct {
    logic               op;
    logic [COUNT_W-1:0] capture_count;
  } edge_item_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                cfg_wr_en = 1'b0;
  logic [THRESH_W-1:0] cfg_wr_data = '0;
  logic                in_push = 1'b0;
  logic                in_full;
  logic                in_op = OP_EDGE;
  logic [COUNT_W-1:0]  in_capture_count = '0;
  logic                out_empty;
  logic                out_pop = 1'b0;
  logic                out_byte_valid;
  logic [BYTE_W-1:0]   out_byte_value;
  logic [INDEX_W-1:0]  out_byte_index;
  logic [EDGE_W-1:0]   out_edge_count;

  // Items waiting to be offered, and decoded bytes waiting to come out.
  edge_item_t pending_edges[$];
  result_t    decoded_results[$];
  int unsigned queued_total = 0;
  int unsigned mismatch_count = 0;
  int unsigned cycle_count;

  // Local copy of the decoder state and its threshold register.
  logic [THRESH_W-1:0] threshold_setting = THRESHOLD_RESET;
  logic                armed_flag = 1'b0;
  logic [EDGE_W-1:0]   edge_tally = '0;
  logic [7:0]          bits_decoded = '0;
  logic [BYTE_W-1:0]   byte_in_progress = '0;

  // Idling control for the driver and the monitor.
  logic idling_on = 1'b1;
  logic long_stall_pending = 1'b0;
  int   send_idle = 0;
  int   pop_idle = 0;
  logic item_taken;

  logic [COUNT_W-1:0] boundary_space [0:3] = '{16'd8007, 16'd8008, 16'hFFFF, 16'h0000};

  ir_pulse_distance_decoder_top dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data),
    .in_push          (in_push),
    .in_full          (in_full),
    .in_op            (in_op),
    .in_capture_count (in_capture_count),
    .out_empty        (out_empty),
    .out_pop          (out_pop),
    .out_byte_valid   (out_byte_valid),
    .out_byte_value   (out_byte_value),
    .out_byte_index   (out_byte_index),
    .out_edge_count   (out_edge_count)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at %0t ns: %s", $realtime, msg);
    mismatch_count++;
  endtask

  // Advance the decoder model by one accepted item and record the result it yields.
  task automatic decode_edge(input edge_item_t it);
    result_t            r;
    logic [THRESH_W-1:0] scaled;
    r = '0;
    scaled = it.capture_count[COUNT_W-1:SCALE_SHIFT];
    if (it.op == OP_CLEAR) begin
      // counters and the partial byte drop back to zero; the armed flag survives
      edge_tally = '0;
      bits_decoded = '0;
      byte_in_progress = '0;
    end else if (!armed_flag) begin
      armed_flag = 1'b1;
    end else begin
      // only odd edges past the leader carry a space length worth decoding
      if (edge_tally >= 2 && edge_tally[0]) begin
        if (scaled > threshold_setting) byte_in_progress[bits_decoded[2:0]] = 1'b1;
        if (bits_decoded[2:0] == 3'd7) begin
          r.byte_valid = 1'b1;
          r.byte_value = byte_in_progress;
          r.byte_index = bits_decoded[7:3];
          byte_in_progress = '0;
        end
        bits_decoded = bits_decoded + 8'd1;
      end
      edge_tally = edge_tally + 8'd1;
    end
    r.edge_count = edge_tally;
    decoded_results.push_back(r);
  endtask

  // Compare the result on the out_ ports with the oldest decoded result.
  task automatic check_result();
    result_t want;
    if (decoded_results.size() == 0) begin
      report_mismatch("result arrived with nothing expected");
      return;
    end
    want = decoded_results.pop_front();
    if (out_byte_valid !== want.byte_valid)
      report_mismatch($sformatf("byte_valid %b, expected %b", out_byte_valid, want.byte_valid));
    if (out_byte_value !== want.byte_value)
      report_mismatch($sformatf("byte_value %h, expected %h", out_byte_value, want.byte_value));
    if (out_byte_index !== want.byte_index)
      report_mismatch($sformatf("byte_index %0d, expected %0d", out_byte_index,
                                want.byte_index));
    if (out_edge_count !== want.edge_count)
      report_mismatch($sformatf("edge_count %0d, expected %0d", out_edge_count,
                                want.edge_count));
  endtask

  task automatic add_item(input logic op, input logic [COUNT_W-1:0] cnt);
    edge_item_t it;
    it.op = op;
    it.capture_count = cnt;
    pending_edges.push_back(it);
    queued_total++;
  endtask

  // Pick a space length that decodes to the wanted bit under the current threshold,
  // leaning on the edges of each range; at the top threshold no count decodes as one.
  function automatic logic [COUNT_W-1:0] space_count(input logic one);
    int unsigned lo, hi;
    if (one && threshold_setting != 13'h1FFF) begin
      lo = (int'(threshold_setting) + 1) * 8;
      hi = 65535;
    end else if (one) begin
      // nothing can exceed the top threshold; offer the largest count instead
      lo = 65528;
      hi = 65535;
    end else begin
      lo = 0;
      hi = int'(threshold_setting) * 8 + 7;
    end
    case ($urandom_range(0, 3))
      0:       return COUNT_W'(lo);
      1:       return COUNT_W'(hi);
      default: return COUNT_W'($urandom_range(hi, lo));
    endcase
  endfunction

  // A frame: optional clear, leader mark and space, then a mark and a space per bit.
  task automatic queue_frame(input int unsigned n_bits, input bit lead_clear);
    int unsigned b;
    if (lead_clear) add_item(OP_CLEAR, COUNT_W'($urandom_range(0, 65535)));
    add_item(OP_EDGE, COUNT_W'($urandom_range(0, 65535)));
    add_item(OP_EDGE, COUNT_W'($urandom_range(0, 65535)));
    for (b = 0; b < n_bits; b++) begin
      add_item(OP_EDGE, COUNT_W'($urandom_range(0, 65535)));
      add_item(OP_EDGE, space_count(1'($urandom_range(0, 1))));
    end
  endtask

  // Mostly well-formed frames of random length, with broken ones and loose noise.
  task automatic queue_traffic(input int unsigned n_items);
    int unsigned target;
    target = queued_total + n_items;
    while (queued_total < target) begin
      if ($urandom_range(0, 9) == 0)
        add_item(1'($urandom_range(0, 1)), COUNT_W'($urandom_range(0, 65535)));
      else if ($urandom_range(0, 3) == 0)
        queue_frame($urandom_range(0, 40), $urandom_range(0, 7) != 0);
      else
        queue_frame($urandom_range(8, 16), $urandom_range(0, 7) != 0);
    end
  endtask

  // Hold until every item is taken and every result has come out, then let the
  // pipeline settle.
  task automatic wait_drained();
    while (pending_edges.size() != 0 || decoded_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Write the threshold while the block is idle; the model takes the same value.
  task automatic write_threshold(input logic [THRESH_W-1:0] value);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= value;
    threshold_setting = value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // Driver: take the offered item when the block accepts it, then decide whether to
  // offer the next one or sit out an idle burst.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_push <= 1'b0;
    end else begin
      item_taken = in_push && !in_full;
      if (item_taken) begin
        decode_edge(pending_edges[0]);
        void'(pending_edges.pop_front());
      end
      if (send_idle > 0) begin
        send_idle--;
      end else if (idling_on && pending_edges.size() != 0 && (item_taken || !in_push) &&
                   $urandom_range(0, 11) == 0) begin
        send_idle = $urandom_range(1, 17);
      end
      if (send_idle == 0 && pending_edges.size() != 0) begin
        in_push <= 1'b1;
        in_op <= pending_edges[0].op;
        in_capture_count <= pending_edges[0].capture_count;
      end else begin
        in_push <= 1'b0;
      end
    end
  end

  // Monitor: check each popped result, then decide whether to pop next cycle. A long
  // hold-off request overrides the short bursts so that both queues fill up.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_pop <= 1'b0;
    end else begin
      if (out_pop && !out_empty) check_result();
      if (long_stall_pending) begin
        pop_idle = LONG_STALL;
        long_stall_pending <= 1'b0;
      end else if (pop_idle > 0) begin
        pop_idle--;
      end else if (idling_on && $urandom_range(0, 7) == 0) begin
        pop_idle = $urandom_range(1, 17);
      end
      out_pop <= (pop_idle == 0);
    end
  end

  // Watchdog: end the run if it hangs.
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    int unsigned i;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part at the reset threshold: clear before arming, the arming edge,
    // leader skip, one byte built from boundary space lengths, then a clear mid-frame.
    add_item(OP_CLEAR, 16'hFFFF);
    add_item(OP_EDGE, 16'h0000);
    add_item(OP_EDGE, 16'hFFFF);
    add_item(OP_EDGE, 16'h0000);
    for (i = 0; i < 8; i++) begin
      add_item(OP_EDGE, i[0] ? 16'hFFFF : 16'h0000);
      add_item(OP_EDGE, boundary_space[i[1:0]]);
    end
    add_item(OP_CLEAR, 16'h0000);
    add_item(OP_EDGE, 16'hFFFF);
    add_item(OP_EDGE, 16'h0000);
    wait_drained();

    // Lowest threshold; hold the receiver off for a long stretch so the input stalls.
    write_threshold(13'd0);
    queue_traffic(80);
    long_stall_pending <= 1'b1;
    wait_drained();

    // Highest threshold: no space can decode as one.
    write_threshold(13'h1FFF);
    queue_traffic(60);
    wait_drained();

    // One long frame behind a single leading clear: edge counter and bit position both
    // wrap, and the byte index runs up to its top value.
    write_threshold(THRESH_W'($urandom_range(1, 8190)));
    queue_frame(260, 1'b1);
    wait_drained();

    write_threshold(13'd1);
    queue_traffic(40);
    wait_drained();

    // Last part runs flat out on both sides.
    idling_on <= 1'b0;
    write_threshold(13'd8190);
    queue_traffic(40);
    wait_drained();
    repeat (8) @(posedge clk);

    if (decoded_results.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", decoded_results.size()));
    if (mismatch_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

`default_nettype wire

>>> filelist.f
rtl/core/ipd_pkg.sv
rtl/core/ipd_fifo.sv
rtl/core/ipd_front.sv
rtl/core/ipd_back.sv
rtl/core/ir_pulse_distance_decoder_top.sv
dv/testbench.sv
